>>> rtl/assert_macros.svh
// assertion macros for the checker file okbs_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication within the same cycle, gated by active-low reset
`define OKBS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// implication into the next cycle, gated by active-low reset
`define OKBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

>>> rtl/okbs_pkg.sv
// shared constants and register codes for the byte stream decryptor
// no dependencies
`default_nettype none

package okbs_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned POS_W       = 64;
  localparam int unsigned INNER_IDX_W = 4;
  localparam int unsigned OUTER_IDX_W = 5;

  // outer key storage holds three 64-bit words
  localparam logic [OUTER_IDX_W-1:0] OUTER_KEY_BYTES = 5'd24;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_KEY_LO = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_KEY_HI = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_KEY_W0 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_KEY_W1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_KEY_W2 = 3'd5;

  // stages in the start offset residue pipeline
  localparam int unsigned       SETTLE_W = 3;
  localparam logic [SETTLE_W-1:0] MOD_LAT = 3'd4;

endpackage

`default_nettype wire

>>> rtl/okbs_stream_ifs.sv
// valid/ready channel interfaces for cipher bytes in and plain bytes out
// depends on okbs_pkg
`default_nettype none

interface okbs_in_if;
  logic                         valid;
  logic                         ready;
  logic [okbs_pkg::BYTE_W-1:0]  cipher_byte;
  logic                         restart;

  modport source (output valid, output cipher_byte, output restart, input ready);
  modport sink   (input valid, input cipher_byte, input restart, output ready);
endinterface

interface okbs_out_if;
  logic                         valid;
  logic                         ready;
  logic [okbs_pkg::BYTE_W-1:0]  plain_byte;

  modport source (output valid, output plain_byte, input ready);
  modport sink   (input valid, input plain_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/okbs_mod_const.sv
// pipelined residue of a 64-bit value modulo a small constant
// depends on okbs_pkg; four register stages (okbs_pkg::MOD_LAT)
`default_nettype none

module okbs_mod_const #(
  parameter int unsigned MODULUS = 17,
  parameter int unsigned RES_W   = 5
) (
  input  wire logic                           clk,
  input  wire logic [okbs_pkg::POS_W-1:0]     value_i,
  output logic      [RES_W-1:0]               res_o
);

  // 256^k mod MODULUS, worked out at elaboration
  localparam int unsigned W0 = 1 % MODULUS;
  localparam int unsigned W1 = (W0 * 256) % MODULUS;
  localparam int unsigned W2 = (W1 * 256) % MODULUS;
  localparam int unsigned W3 = (W2 * 256) % MODULUS;
  localparam int unsigned W4 = (W3 * 256) % MODULUS;
  localparam int unsigned W5 = (W4 * 256) % MODULUS;
  localparam int unsigned W6 = (W5 * 256) % MODULUS;
  localparam int unsigned W7 = (W6 * 256) % MODULUS;
  localparam int unsigned WGT [8] = '{W0, W1, W2, W3, W4, W5, W6, W7};
  localparam int unsigned RECIP   = 65536 / MODULUS;

  logic [15:0] s1_r, s1_nxt;
  logic [12:0] s2_r, s2_nxt;
  logic [12:0] q_r, q_nxt;
  logic [12:0] v_r;
  logic [RES_W-1:0] res_r, res_nxt;
  logic [29:0] prod;
  logic [12:0] qm;
  logic [12:0] rem;

  // byte-weighted sum, at most 8 * 255 * 23
  always_comb begin
    s1_nxt = '0;
    for (int k = 0; k < 8; k++) begin
      s1_nxt = s1_nxt + 16'(value_i[8*k +: 8]) * 16'(WGT[k]);
    end
  end

  // fold the high byte back, at most 255 + 255 * 23
  assign s2_nxt = 13'(s1_r[7:0]) + 13'(s1_r[15:8]) * 13'(W1);

  // reciprocal quotient, low by at most one
  assign prod  = 30'(s2_r) * 30'(RECIP);
  assign q_nxt = 13'(prod >> 16);

  assign qm = 13'(q_r * 13'(MODULUS));

  always_comb begin
    rem = v_r - qm;
    if (rem >= 13'(MODULUS)) begin
      rem = rem - 13'(MODULUS);
    end
    res_nxt = RES_W'(rem);
  end

  always_ff @(posedge clk) begin
    s1_r  <= s1_nxt;
    s2_r  <= s2_nxt;
    q_r   <= q_nxt;
    v_r   <= s2_r;
    res_r <= res_nxt;
  end

  assign res_o = res_r;

endmodule

`default_nettype wire

>>> rtl/offset_keyed_byte_stream_decrypt_top.sv
// top level of the offset-keyed byte stream decryptor
// depends on okbs_pkg, okbs_stream_ifs (okbs_in_if, okbs_out_if) and okbs_mod_const
//
// usage
//   in_ch carries one cipher byte per request plus a restart flag; out_ch
//   returns one plain byte per request, in order
//   cfg_we/cfg_index/cfg_wdata write the start offset and the key words;
//   writes take effect at the clock edge, indexes past the list are ignored
//   an accepted request's plain byte is registered and driven onto out_ch;
//   throughput is one byte per cycle while out_ch is not stalled
//   the output register lets a new request in while the held byte is taken
//   in the same cycle; while out_ch is stalled in_ch.ready stays low
//   reset clears position, indices, keys and start offset and drops out_ch.valid
//   after reset and after every start offset write, in_ch.ready stays low until
//   the settle counter runs out: the residues of the start offset modulo both
//   key lengths come out of a four-stage constant-modulus pipeline
//   restart loads the position from the start offset before the byte is
//   handled; the key indices then step along with the position and both
//   drop to zero when the position wraps from all ones
`default_nettype none

module offset_keyed_byte_stream_decrypt_top #(
  parameter int unsigned INNER_KEY_LEN = 16,
  parameter int unsigned OUTER_KEY_LEN = 17
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  okbs_in_if.sink                                  in_ch,
  okbs_out_if.source                               out_ch,
  input  wire logic                                cfg_we,
  input  wire logic [okbs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [okbs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int unsigned IW = okbs_pkg::INNER_IDX_W;
  localparam int unsigned OW = okbs_pkg::OUTER_IDX_W;
  localparam int unsigned PW = okbs_pkg::POS_W;
  localparam int unsigned BW = okbs_pkg::BYTE_W;

  localparam logic [IW-1:0] INNER_LAST = IW'(INNER_KEY_LEN - 1);
  localparam logic [OW-1:0] OUTER_LAST = OW'(OUTER_KEY_LEN - 1);

  // configuration registers
  logic [PW-1:0] start_offset_r;
  logic [63:0]   inner_key_lo_r;
  logic [63:0]   inner_key_hi_r;
  logic [63:0]   outer_key_w0_r;
  logic [63:0]   outer_key_w1_r;
  logic [63:0]   outer_key_w2_r;

  // stream state
  logic [PW-1:0] pos_r, pos_nxt;
  logic [IW-1:0] in_idx_r, in_idx_nxt;
  logic [OW-1:0] out_idx_r, out_idx_nxt;

  // settle counter for the residue pipeline
  logic [okbs_pkg::SETTLE_W-1:0] settle_r, settle_nxt;

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic [BW-1:0] plain_r;

  logic [IW-1:0] start_in_res;
  logic [OW-1:0] start_out_res;

  logic          accept;
  logic [PW-1:0] cur_pos;
  logic [IW-1:0] cur_in_idx;
  logic [OW-1:0] cur_out_idx;
  logic [15:0][BW-1:0] inner_bytes;
  logic [23:0][BW-1:0] outer_bytes;
  logic [BW-1:0] inner_key;
  logic [BW-1:0] outer_key;
  logic [BW-1:0] pre;
  logic [BW-1:0] mix;
  logic [BW-1:0] plain_nxt;

  // start offset residues modulo each key length
  okbs_mod_const #(
    .MODULUS (INNER_KEY_LEN),
    .RES_W   (IW)
  ) u_mod_inner (
    .clk     (clk),
    .value_i (start_offset_r),
    .res_o   (start_in_res)
  );

  okbs_mod_const #(
    .MODULUS (OUTER_KEY_LEN),
    .RES_W   (OW)
  ) u_mod_outer (
    .clk     (clk),
    .value_i (start_offset_r),
    .res_o   (start_out_res)
  );

  // ready once residues are current and the output slot frees up
  assign in_ch.ready = (settle_r == '0) && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  // restart picks the start offset and its residues
  always_comb begin
    if (in_ch.restart) begin
      cur_pos     = start_offset_r;
      cur_in_idx  = start_in_res;
      cur_out_idx = start_out_res;
    end else begin
      cur_pos     = pos_r;
      cur_in_idx  = in_idx_r;
      cur_out_idx = out_idx_r;
    end
  end

  // key byte selection
  assign inner_bytes = {inner_key_hi_r, inner_key_lo_r};
  assign outer_bytes = {outer_key_w2_r, outer_key_w1_r, outer_key_w0_r};
  assign inner_key   = inner_bytes[cur_in_idx];

  always_comb begin
    if (cur_out_idx < okbs_pkg::OUTER_KEY_BYTES) begin
      outer_key = outer_bytes[cur_out_idx];
    end else begin
      outer_key = '0;
    end
  end

  // byte transform
  assign pre       = in_ch.cipher_byte ^ outer_key;
  assign mix       = cur_pos[7:0] ^ cur_pos[15:8] ^ cur_pos[23:16] ^ cur_pos[31:24];
  assign plain_nxt = pre ^ {pre[3:0], 4'b0000} ^ inner_key ^ mix;

  // position and index stepping, indices wrap at the key lengths
  always_comb begin
    pos_nxt     = pos_r;
    in_idx_nxt  = in_idx_r;
    out_idx_nxt = out_idx_r;
    if (accept) begin
      pos_nxt = cur_pos + 1'b1;
      if (&cur_pos) begin
        // position wraps to zero, so both residues restart at zero
        in_idx_nxt  = '0;
        out_idx_nxt = '0;
      end else begin
        in_idx_nxt  = (cur_in_idx == INNER_LAST) ? '0 : cur_in_idx + 1'b1;
        out_idx_nxt = (cur_out_idx == OUTER_LAST) ? '0 : cur_out_idx + 1'b1;
      end
    end
  end

  // a start offset write restarts the settle count
  always_comb begin
    settle_nxt = settle_r;
    if (cfg_we && (cfg_index == okbs_pkg::REG_START_OFFSET)) begin
      settle_nxt = okbs_pkg::MOD_LAT;
    end else if (settle_r != '0) begin
      settle_nxt = settle_r - 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      in_idx_r    <= '0;
      out_idx_r   <= '0;
      settle_r    <= okbs_pkg::MOD_LAT;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      in_idx_r    <= in_idx_nxt;
      out_idx_r   <= out_idx_nxt;
      settle_r    <= settle_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      plain_r <= plain_nxt;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_offset_r <= '0;
      inner_key_lo_r <= '0;
      inner_key_hi_r <= '0;
      outer_key_w0_r <= '0;
      outer_key_w1_r <= '0;
      outer_key_w2_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        okbs_pkg::REG_START_OFFSET: start_offset_r <= cfg_wdata;
        okbs_pkg::REG_INNER_KEY_LO: inner_key_lo_r <= cfg_wdata;
        okbs_pkg::REG_INNER_KEY_HI: inner_key_hi_r <= cfg_wdata;
        okbs_pkg::REG_OUTER_KEY_W0: outer_key_w0_r <= cfg_wdata;
        okbs_pkg::REG_OUTER_KEY_W1: outer_key_w1_r <= cfg_wdata;
        okbs_pkg::REG_OUTER_KEY_W2: outer_key_w2_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.plain_byte = plain_r;

endmodule

`default_nettype wire

>>> rtl/okbs_checker.sv
// port-level checks for the byte stream decryptor, bound to the top level
// depends on okbs_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module okbs_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_valid,
  input wire logic                             in_ready,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic [okbs_pkg::BYTE_W-1:0]      out_plain,
  input wire logic                             cfg_we,
  input wire logic [okbs_pkg::CFG_IDX_W-1:0]   cfg_index
);

  `OKBS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_plain))
  `OKBS_ASSERT_NEXT(a_accept_gives_result, clk, rst_n, in_valid && in_ready, out_valid)
  `OKBS_ASSERT_SAME(a_no_accept_on_stall, clk, rst_n, out_valid && !out_ready, !in_ready)
  `OKBS_ASSERT_NEXT(a_offset_write_blocks, clk, rst_n, cfg_we && (cfg_index == okbs_pkg::REG_START_OFFSET), !in_ready)

endmodule

bind offset_keyed_byte_stream_decrypt_top okbs_checker u_okbs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_plain (out_ch.plain_byte),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index)
);

`default_nettype wire

>>> bench/tb_offset_keyed_byte_stream_decrypt_top.sv
// self-checking testbench for offset_keyed_byte_stream_decrypt_top
// needs okbs_pkg, okbs_stream_ifs and the decryptor rtl; an internal predictor
// models position, key indices and registers and checks every plain byte
`timescale 1ns / 100ps

module tb_offset_keyed_byte_stream_decrypt_top;

  localparam int unsigned INNER_LEN = 16;
  localparam int unsigned OUTER_LEN = 17;

  // indexes past the register list, writes there must be dropped
  localparam logic [okbs_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [okbs_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned DRAIN_CYCLES = 8;
  // far above the slowest legal run: ~500 requests with long stalls on both sides
  localparam longint unsigned WATCHDOG_NS = 64'd5_000_000;

  logic                              clk;
  logic                              rst_n;
  logic                              cfg_we;
  logic [okbs_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [okbs_pkg::CFG_DATA_W-1:0]   cfg_wdata;

  okbs_in_if  in_bus();
  okbs_out_if out_bus();

  offset_keyed_byte_stream_decrypt_top #(
    .INNER_KEY_LEN (INNER_LEN),
    .OUTER_KEY_LEN (OUTER_LEN)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus.sink),
    .out_ch    (out_bus.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // predictor state: register shadows plus the stream position
  // ---------------------------------------------------------------------------
  logic [63:0] start_shadow;
  logic [63:0] inner_key_words [2];
  logic [63:0] outer_key_words [3];
  logic [63:0] model_position;

  // plain bytes still owed by the block, oldest first
  logic [7:0] expected_plain [$];

  // bookkeeping
  int unsigned fail_count;
  int unsigned bytes_sent;
  int unsigned bytes_checked;
  int unsigned restarts_sent;
  int unsigned cfg_writes;

  // idling controls shared by the test tasks, the request helpers and the ready process
  bit          src_gaps_on;
  bit          sink_gaps_on;
  int unsigned sink_hold_req;
  bit          sink_holding;

  // ---------------------------------------------------------------------------
  // clock and watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(WATCHDOG_NS);
    $display("timeout: %0d plain bytes still owed", expected_plain.size());
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor: one cipher byte in, the plain byte the block must return
  // restart reloads the position first; the indices are the residues of the
  // position at the time the byte is handled, then the position steps by one
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] decrypt_byte(input logic [7:0] cipher, input logic restart);
    logic [63:0] pos;
    logic [3:0]  inner_idx;
    logic [4:0]  outer_idx;
    logic [7:0]  outer_kb;
    logic [7:0]  inner_kb;
    logic [7:0]  pre;
    logic [7:0]  mix;
    if (restart) begin
      model_position = start_shadow;
    end
    pos       = model_position;
    inner_idx = 4'(pos % INNER_LEN);
    outer_idx = 5'(pos % OUTER_LEN);
    // an index past the stored words reads zero
    outer_kb  = 8'h00;
    if (outer_idx < okbs_pkg::OUTER_KEY_BYTES) begin
      outer_kb = outer_key_words[outer_idx[4:3]][outer_idx[2:0]*8 +: 8];
    end
    inner_kb  = inner_key_words[inner_idx[3]][inner_idx[2:0]*8 +: 8];
    pre       = cipher ^ outer_kb;
    // fold of the four low position bytes
    mix       = pos[7:0] ^ pos[15:8] ^ pos[23:16] ^ pos[31:24];
    model_position = model_position + 64'd1;
    return pre ^ {pre[3:0], 4'b0000} ^ inner_kb ^ mix;
  endfunction

  // ---------------------------------------------------------------------------
  // failure reporting, only the first few are printed in full
  // ---------------------------------------------------------------------------
  task automatic report_failure(input string what, input logic [7:0] want,
                                input logic [7:0] got);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("[%0t] %s: expected %02h, got %02h", $time, what, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // gap lengths: mostly none, some short, a few long
  // ---------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) begin
      return 0;
    end
    if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, 30);
  endfunction

  // ---------------------------------------------------------------------------
  // result side: ready pattern, with a long hold when a test asks for one
  // ---------------------------------------------------------------------------
  initial begin : sink_ready_gen
    int unsigned n;
    out_bus.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) begin
      @(posedge clk);
    end
    forever begin
      if (sink_hold_req > 0) begin
        // long hold, counted here so the sender keeps pushing meanwhile
        n = sink_hold_req;
        sink_hold_req = 0;
        sink_holding  = 1'b1;
        out_bus.ready <= 1'b0;
        repeat (n) @(posedge clk);
        sink_holding  = 1'b0;
        out_bus.ready <= 1'b1;
        @(posedge clk);
      end else begin
        n = sink_gaps_on ? pick_gap() : 0;
        if (n > 0) begin
          out_bus.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: every plain byte taken is compared with the oldest owed one
  // ---------------------------------------------------------------------------
  initial begin : plain_byte_check
    logic [7:0] want;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready) begin
        if (expected_plain.size() == 0) begin
          report_failure("plain byte with nothing owed", 8'h00, out_bus.plain_byte);
        end else begin
          want = expected_plain.pop_front();
          bytes_checked++;
          if (out_bus.plain_byte !== want) begin
            report_failure("plain_byte mismatch", want, out_bus.plain_byte);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // request side helpers; all called at a rising edge
  // ---------------------------------------------------------------------------

  // offer one cipher byte, hold it until taken, then log the owed plain byte
  task automatic send_byte(input logic [7:0] cipher, input logic restart);
    int unsigned gap;
    logic [7:0]  owed;
    gap = src_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.cipher_byte <= cipher;
    in_bus.restart     <= restart;
    do begin
      @(posedge clk);
    end while (!in_bus.ready);
    owed = decrypt_byte(cipher, restart);
    expected_plain = {expected_plain, owed};
    bytes_sent++;
    if (restart) begin
      restarts_sent++;
    end
  endtask

  // stop offering and wait until every owed plain byte has come back
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (expected_plain.size() > 0);
  endtask

  // one register write; only issued while the block is idle
  task automatic write_reg(input logic [okbs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      okbs_pkg::REG_START_OFFSET: start_shadow       = data;
      okbs_pkg::REG_INNER_KEY_LO: inner_key_words[0] = data;
      okbs_pkg::REG_INNER_KEY_HI: inner_key_words[1] = data;
      okbs_pkg::REG_OUTER_KEY_W0: outer_key_words[0] = data;
      okbs_pkg::REG_OUTER_KEY_W1: outer_key_words[1] = data;
      okbs_pkg::REG_OUTER_KEY_W2: outer_key_words[2] = data;
      default: ;
    endcase
    cfg_we <= 1'b0;
    cfg_writes++;
    @(posedge clk);
  endtask

  task automatic write_all_keys(input logic [63:0] ilo, input logic [63:0] ihi,
                                input logic [63:0] o0, input logic [63:0] o1,
                                input logic [63:0] o2);
    write_reg(okbs_pkg::REG_INNER_KEY_LO, ilo);
    write_reg(okbs_pkg::REG_INNER_KEY_HI, ihi);
    write_reg(okbs_pkg::REG_OUTER_KEY_W0, o0);
    write_reg(okbs_pkg::REG_OUTER_KEY_W1, o1);
    write_reg(okbs_pkg::REG_OUTER_KEY_W2, o2);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // ---------------------------------------------------------------------------
  // directed tests
  // ---------------------------------------------------------------------------

  // keys and start offset at their reset value of zero
  task automatic test_zero_keys();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h0F, 1'b1);
    send_byte(8'hF0, 1'b0);
    wait_drained();
  endtask

  // all-ones keys, then a mixed pattern so each key byte lane differs
  task automatic test_key_extremes();
    write_all_keys(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    wait_drained();
    write_all_keys(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                   64'h8040_2010_0804_0201, 64'h5AA5_3CC3_0FF0_6996,
                   64'hDEAD_BEEF_CAFE_F00D);
    send_byte(8'hA5, 1'b1);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'hFF, 1'b0);
    wait_drained();
  endtask

  // position wraps from all ones to zero; indices must follow
  task automatic test_position_wrap();
    write_reg(okbs_pkg::REG_START_OFFSET, ALL_ONES - 64'd3);
    send_byte(8'h3C, 1'b1);
    repeat (7) send_byte(8'($urandom()), 1'b0);
    wait_drained();
  endtask

  // a start offset write alone leaves the running position untouched
  task automatic test_deferred_offset();
    write_reg(okbs_pkg::REG_START_OFFSET, 64'h0000_0000_FFFF_FFFE);
    send_byte(8'h81, 1'b0);
    send_byte(8'h7E, 1'b0);
    send_byte(8'hC3, 1'b1);
    send_byte(8'h18, 1'b0);
    wait_drained();
  endtask

  // writes to the unused indexes must not reach any register
  task automatic test_ignored_index();
    write_reg(REG_SPARE_6, rand64());
    write_reg(REG_SPARE_7, ALL_ONES);
    send_byte(8'h66, 1'b1);
    send_byte(8'h99, 1'b0);
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // random tests
  // ---------------------------------------------------------------------------

  // phases of random bytes, each with its own keys, start offset and idling
  task automatic test_random_stream();
    logic [63:0] start_pick;
    for (int phase = 0; phase < 6; phase++) begin
      // phase 0 runs with no idling on either side
      src_gaps_on  = (phase != 0) && ($urandom_range(0, 3) != 0);
      sink_gaps_on = (phase != 0) && ($urandom_range(0, 3) != 0);
      case (phase)
        1:       write_all_keys(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
        2:       write_all_keys('0, '0, '0, '0, '0);
        default: write_all_keys(rand64(), rand64(), rand64(), rand64(), rand64());
      endcase
      case ($urandom_range(0, 4))
        0:       start_pick = '0;
        1:       start_pick = ALL_ONES;
        2:       start_pick = ALL_ONES - 64'($urandom_range(1, 40));
        3:       start_pick = {32'h0, 32'hFFFF_FFF0};
        default: start_pick = rand64();
      endcase
      write_reg(okbs_pkg::REG_START_OFFSET, start_pick);
      for (int k = 0; k < 70; k++) begin
        if (k == 35) begin
          // sender pauses for a full drain, then a fresh offset that only the
          // next restart picks up
          wait_drained();
          write_reg(okbs_pkg::REG_START_OFFSET, rand64());
        end
        send_byte(8'($urandom()), (k == 0) || ($urandom_range(0, 29) == 0));
      end
      wait_drained();
    end
  endtask

  // long receiver hold while the sender keeps offering: the block must fill
  // and stall its input, then drain in order
  task automatic test_output_stall();
    src_gaps_on   = 1'b0;
    sink_gaps_on  = 1'b0;
    sink_hold_req = 120;
    while (!sink_holding) begin
      @(posedge clk);
    end
    send_byte(8'($urandom()), 1'b1);
    repeat (29) send_byte(8'($urandom()), 1'b0);
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= okbs_pkg::REG_START_OFFSET;
    cfg_wdata          <= '0;
    in_bus.valid       <= 1'b0;
    in_bus.cipher_byte <= '0;
    in_bus.restart     <= 1'b0;
    start_shadow       = '0;
    inner_key_words    = '{default: '0};
    outer_key_words    = '{default: '0};
    model_position     = '0;
    fail_count         = 0;
    bytes_sent         = 0;
    bytes_checked      = 0;
    restarts_sent      = 0;
    cfg_writes         = 0;
    src_gaps_on        = 1'b1;
    sink_gaps_on       = 1'b1;
    sink_hold_req      = 0;
    sink_holding       = 1'b0;

    // hold the synchronous reset, then release it at a rising edge
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_zero_keys();
    test_key_extremes();
    test_position_wrap();
    test_deferred_offset();
    test_ignored_index();
    test_random_stream();
    test_output_stall();

    // nothing owed any more; keep the clock running so a stray byte can show
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_plain.size() > 0) begin
      fail_count++;
      $display("%0d plain bytes never returned", expected_plain.size());
    end

    $display("sent %0d cipher bytes (%0d restarts), checked %0d plain bytes",
             bytes_sent, restarts_sent, bytes_checked);
    $display("%0d register writes, %0d failures", cfg_writes, fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
